// ===== hdl/longest_window_k_distinct_assert.svh =====
// Assertion macros used by the longest-window back part.
`ifndef LONGEST_WINDOW_K_DISTINCT_ASSERT_SVH
`define LONGEST_WINDOW_K_DISTINCT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define LWKD_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define LWKD_IMPLIES_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lwkd_pkg.sv =====
// Shared constants, types and helpers of the longest-window block.
package lwkd_pkg;

  localparam int ALPHABET    = 26;
  localparam int MAX_LEN     = 1024;
  localparam int SYM_W       = 5;
  localparam int LIM_W       = 5;
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int POS_W       = ADDR_W + 1;
  localparam int OUT_W       = 11;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;
  localparam int OUT_USER_W  = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(2);

  // One symbol as it waits between the front and back parts.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             drop;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0] best_start;
    logic [OUT_W-1:0] best_length;
    logic             few_distinct;
    logic             too_long;
  } result_t;

  // Symbols beyond the alphabet fold onto its last entry.
  function automatic logic [SYM_W-1:0] clamp_symbol(input logic [SYM_W-1:0] s);
    logic [SYM_W-1:0] top_sym;
    top_sym = SYM_W'(ALPHABET - 1);
    return (s > top_sym) ? top_sym : s;
  endfunction

endpackage

// ===== hdl/lwkd_front.sv =====
// Front part: accepts symbols, clamps them and marks symbols past the capacity.
module lwkd_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lwkd_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [4:0] symbol
  input  logic                             s_axis_tlast,  // last_symbol
  output logic                             push,
  output lwkd_pkg::item_t                  push_item,
  input  logic                             q_full
);
  import lwkd_pkg::*;

  logic [POS_W-1:0] str_count;
  logic             accept;
  logic             drop;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && !q_full;
  assign drop          = (str_count == POS_W'(MAX_LEN));

  assign push           = accept;
  assign push_item.sym  = clamp_symbol(s_axis_tdata[SYM_W-1:0]);
  assign push_item.last = s_axis_tlast;
  assign push_item.drop = drop;

  // Symbols seen in the current string, saturating at the capacity.
  always_ff @(posedge clk) begin
    if (rst) begin
      str_count <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        str_count <= '0;
      end else if (!drop) begin
        str_count <= str_count + POS_W'(1);
      end
    end
  end

endmodule

// ===== hdl/lwkd_queue.sv =====
// Short request queue between the front and back parts.
module lwkd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lwkd_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output lwkd_pkg::item_t pop_item,
  output logic            not_empty
);
  import lwkd_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/lwkd_back.sv =====
// Back part: history store, symbol counts, window shrinking and the result register.
`include "longest_window_k_distinct_assert.svh"

module lwkd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lwkd_pkg::LIM_W-1:0] limit,
  input  logic                       q_valid,
  input  lwkd_pkg::item_t            q_item,
  output logic                       q_pop,
  output logic                       res_valid,
  input  logic                       res_ready,
  output lwkd_pkg::result_t          res_data
);
  import lwkd_pkg::*;

  typedef enum logic [3:0] {
    S_TAKE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_SHRINK = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t            state;
  logic [SYM_W-1:0]  history [MAX_LEN];
  logic [SYM_W-1:0]  hist_q;
  logic [POS_W-1:0]  counts [ALPHABET];
  logic [LIM_W-1:0]  window_distinct;
  logic [LIM_W-1:0]  total_distinct;
  logic [ALPHABET-1:0] seen;
  logic [POS_W-1:0]  position;
  logic [ADDR_W-1:0] window_start;
  logic [POS_W-1:0]  best_length;
  logic [ADDR_W-1:0] best_start;
  logic              overflow;
  logic              cur_last;

  logic [LIM_W-1:0]  limit_eff;
  logic              take;
  logic [SYM_W-1:0]  cnt_addr;
  logic [POS_W-1:0]  cnt_rd;
  logic              over;
  logic [POS_W-1:0]  win_len;
  logic              load_res;
  result_t           res_next;

  assign limit_eff = (limit == '0) ? LIM_W'(1) : limit;
  assign take      = (state == S_TAKE) && q_valid;
  assign q_pop     = take;
  // One count read per cycle: the new symbol, or the symbol leaving the window.
  assign cnt_addr  = (state == S_SHRINK) ? hist_q : q_item.sym;
  assign cnt_rd    = counts[cnt_addr];
  assign over      = (window_distinct > limit_eff);
  assign win_len   = position - POS_W'(window_start) + POS_W'(1);
  assign load_res  = (state == S_EMIT) && (!res_valid || res_ready);

  always_comb begin
    res_next = '0;
    if (overflow) begin
      res_next.too_long = 1'b1;
    end else if (total_distinct < limit_eff) begin
      res_next.best_start   = OUT_W'(1);
      res_next.best_length  = OUT_W'(position);
      res_next.few_distinct = 1'b1;
    end else begin
      res_next.best_start  = OUT_W'(best_start) + OUT_W'(1);
      res_next.best_length = OUT_W'(best_length);
    end
  end

  // History memory: written at the current position, read at the window start.
  always_ff @(posedge clk) begin
    if (take && !q_item.drop) begin
      history[position[ADDR_W-1:0]] <= q_item.sym;
    end
    hist_q <= history[window_start];
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_data <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_TAKE;
      for (int i = 0; i < ALPHABET; i++) begin
        counts[i] <= '0;
      end
      window_distinct <= '0;
      total_distinct  <= '0;
      seen            <= '0;
      position        <= '0;
      window_start    <= '0;
      best_length     <= '0;
      best_start      <= '0;
      overflow        <= 1'b0;
      cur_last        <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_TAKE: begin
          if (q_valid) begin
            cur_last <= q_item.last;
            if (q_item.drop) begin
              overflow <= 1'b1;
              state    <= q_item.last ? S_EMIT : S_TAKE;
            end else begin
              counts[q_item.sym] <= cnt_rd + POS_W'(1);
              if (cnt_rd == '0) begin
                window_distinct <= window_distinct + LIM_W'(1);
              end
              if (!seen[q_item.sym]) begin
                seen[q_item.sym] <= 1'b1;
                total_distinct   <= total_distinct + LIM_W'(1);
              end
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (over) begin
            state <= S_SHRINK;
          end else begin
            if (win_len > best_length) begin
              best_length <= win_len;
              best_start  <= window_start;
            end
            position <= position + POS_W'(1);
            state    <= cur_last ? S_EMIT : S_TAKE;
          end
        end
        S_SHRINK: begin
          if (cnt_rd != '0) begin
            counts[hist_q] <= cnt_rd - POS_W'(1);
            if (cnt_rd == POS_W'(1)) begin
              window_distinct <= window_distinct - LIM_W'(1);
            end
          end
          window_start <= window_start + ADDR_W'(1);
          state        <= S_CHECK;
        end
        S_EMIT: begin
          if (load_res) begin
            for (int i = 0; i < ALPHABET; i++) begin
              counts[i] <= '0;
            end
            window_distinct <= '0;
            total_distinct  <= '0;
            seen            <= '0;
            position        <= '0;
            window_start    <= '0;
            best_length     <= '0;
            best_start      <= '0;
            overflow        <= 1'b0;
            state           <= S_TAKE;
          end
        end
        default: begin
          state <= S_TAKE;
        end
      endcase
    end
  end

  `LWKD_HOLDS(a_window_le_total, window_distinct <= total_distinct, "window distinct above total")
  `LWKD_HOLDS(a_start_le_pos, POS_W'(window_start) <= position, "window start passed position")
  `LWKD_IMPLIES_NEXT(a_shrink_step, state == S_SHRINK, window_start == $past(window_start) + ADDR_W'(1), "shrink did not advance")
  `LWKD_IMPLIES_NEXT(a_emit_clears, load_res, res_valid && position == '0 && window_distinct == '0, "string state not cleared")

endmodule

// ===== hdl/longest_window_k_distinct.sv =====
// Top level of the longest window with at most k distinct symbols.
//
// Usage: a string arrives one symbol per request on the s_axis channel, the
// symbol index in tdata and tlast set on its final symbol. The limit on
// distinct symbols is written on the cfg channel, which is always ready; it
// should be written while no string is in flight. After the final symbol the
// block gives one request on m_axis with the 1-based start and the length of
// the first longest window, and flags in tuser for a string with fewer
// distinct symbols than the limit and for a string longer than 1024 symbols.
// The back part takes a new symbol only when done with the last one: a count
// update in S_TAKE, then a window check in S_CHECK, plus a shrink step and
// another check for every symbol that leaves the window on the left, the
// shrink using the registered history memory read. Each symbol leaves at most
// once. With the back part idle, the final symbol passes the queue, the count
// update, the window check and any shrink steps before the result is loaded
// into the output register. A four-entry queue lets the sender run ahead.
// Reset sets the limit to 2 and clears all string state. If the receiver
// stalls, the result waits in the output register; the back part holds the
// next string at its end and the queue then fills and drops s_axis_tready.
module longest_window_k_distinct (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lwkd_pkg::LIM_W-1:0]         cfg_data,      // distinct_limit
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lwkd_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [4:0] symbol
  input  logic                               s_axis_tlast,  // last_symbol
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lwkd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [10:0] best_start, [21:11] best_length
  output logic [lwkd_pkg::OUT_USER_W-1:0]    m_axis_tuser   // [0] few_distinct, [1] too_long
);
  import lwkd_pkg::*;

  logic [LIM_W-1:0] distinct_limit;
  logic             push;
  item_t            push_item;
  logic             q_full;
  logic             q_pop;
  item_t            q_item;
  logic             q_valid;
  result_t          res_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      distinct_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      distinct_limit <= cfg_data;
    end
  end

  lwkd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .push          (push),
    .push_item     (push_item),
    .q_full        (q_full)
  );

  lwkd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_valid)
  );

  lwkd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .limit     (distinct_limit),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res_data  (res_data)
  );

  // Pack the result: start in the low bits, length above, zero fill on top.
  assign m_axis_tdata = {(OUT_DATA_W - 2*OUT_W)'(0), res_data.best_length,
                         res_data.best_start};
  assign m_axis_tuser = {res_data.too_long, res_data.few_distinct};

endmodule

// ===== bench/longest_window_k_distinct_tb.sv =====
// Self-checking bench for the longest window with at most k distinct symbols.
module longest_window_k_distinct_tb;
  import lwkd_pkg::*;

  // One row of the directed part. Rows with typed set carry a result worked
  // out by hand; every other last row is checked against the window predictor.
  typedef struct {
    logic [SYM_W-1:0] sym;
    bit               last;
    bit               typed;
    result_t          want;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [LIM_W-1:0]      cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  // Shadow copy of the block's string state, kept by the predictor.
  logic [SYM_W-1:0] hist [MAX_LEN];
  int unsigned      sym_counts [ALPHABET];
  int unsigned      win_distinct;
  bit [ALPHABET-1:0] seen_syms;
  int unsigned      total_distinct;
  int unsigned      pos;
  int unsigned      win_start;
  int unsigned      best_len;
  int unsigned      best_st;
  bit               overflow;
  logic [LIM_W-1:0] limit_reg;

  // Results still owed by the block, oldest first.
  result_t          pending_results [$];
  row_t             directed_rows [$];

  bit               tx_gaps_on;
  bit               rx_stall_on;
  int               stall_left;
  int unsigned      mismatch_count;
  int unsigned      results_checked;
  int unsigned      symbols_sent;
  int unsigned      strings_sent;

  longest_window_k_distinct dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // [4:0] symbol
    .s_axis_tlast  (s_axis_tlast),  // last_symbol
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),  // [10:0] best_start, [21:11] best_length
    .m_axis_tuser  (m_axis_tuser)   // [0] few_distinct, [1] too_long
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hung handshake ends the run here. The slowest correct run is well under
  // a tenth of this: about 1900 symbols, plus gaps and stalls.
  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_window();
    foreach (sym_counts[i]) sym_counts[i] = 0;
    win_distinct   = 0;
    seen_syms      = '0;
    total_distinct = 0;
    pos            = 0;
    win_start      = 0;
    best_len       = 0;
    best_st        = 0;
    overflow       = 1'b0;
  endtask

  // Takes one accepted symbol into the shadow state. On the last symbol of a
  // string it hands back the result the block owes and starts a fresh string.
  task automatic advance_window(input logic [SYM_W-1:0] raw, input bit last,
                                output bit emits, output result_t res);
    int unsigned sym;
    int unsigned lim;
    int unsigned old;
    int unsigned span;
    // Symbols past the alphabet fold onto its last entry; a zero limit acts
    // as one.
    sym   = (raw >= ALPHABET) ? ALPHABET - 1 : raw;
    lim   = (limit_reg == 0) ? 1 : limit_reg;
    emits = 1'b0;
    res   = '0;
    if (overflow || pos >= MAX_LEN) begin
      overflow = 1'b1;
    end else begin
      hist[pos] = SYM_W'(sym);
      if (sym_counts[sym] == 0) win_distinct++;
      sym_counts[sym]++;
      if (!seen_syms[sym]) begin
        seen_syms[sym] = 1'b1;
        total_distinct++;
      end
      // Drop symbols from the left until the window is back within the limit.
      while (win_distinct > lim && win_start <= pos && win_start < MAX_LEN) begin
        old = hist[win_start];
        if (sym_counts[old] != 0) begin
          sym_counts[old]--;
          if (sym_counts[old] == 0) win_distinct--;
        end
        win_start++;
      end
      span = pos - win_start + 1;
      // Strictly longer only, so the first longest window is kept.
      if (span > best_len) begin
        best_len = span;
        best_st  = win_start;
      end
      pos++;
    end
    if (last) begin
      emits = 1'b1;
      if (overflow) begin
        res.too_long = 1'b1;
      end else if (total_distinct < lim) begin
        res.best_start   = OUT_W'(1);
        res.best_length  = OUT_W'(pos);
        res.few_distinct = 1'b1;
      end else begin
        res.best_start  = OUT_W'(best_st + 1);
        res.best_length = OUT_W'(best_len);
      end
      clear_window();
    end
  endtask

  // Offers one symbol request and waits for it to be taken. The valid is
  // left high so back-to-back requests follow without a gap.
  task automatic send_symbol(input logic [SYM_W-1:0] sym, input bit last,
                             input bit typed, input result_t want);
    bit      emits;
    result_t res;
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(sym);
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    symbols_sent++;
    advance_window(sym, last, emits, res);
    if (emits) begin
      strings_sent++;
      pending_results.push_back(typed ? want : res);
    end
  endtask

  // Random string. Most strings draw from a narrow band of the alphabet so
  // the window keeps shrinking; a few use all of it, and now and then a
  // symbol beyond the alphabet slips in.
  task automatic send_random_string(input int unsigned len, input bit whole_alphabet);
    int unsigned      width;
    int unsigned      base;
    logic [SYM_W-1:0] sym;
    if (whole_alphabet || $urandom_range(0, 7) == 0) begin
      width = ALPHABET;
      base  = 0;
    end else begin
      width = $urandom_range(1, 6);
      base  = $urandom_range(0, ALPHABET - width);
    end
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) sym = SYM_W'($urandom_range(ALPHABET, 31));
      else sym = SYM_W'(base + $urandom_range(0, width - 1));
      send_symbol(sym, i == len - 1, 1'b0, '0);
    end
  endtask

  // Brings the block to rest: no request offered, every owed result in,
  // then a pause that covers the back part finishing its clear.
  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = value;
  endtask

  function automatic void add_row(input logic [SYM_W-1:0] sym, input bit last,
                                  input bit typed, input int unsigned start,
                                  input int unsigned span, input bit few);
    row_t r;
    r.sym                = sym;
    r.last               = last;
    r.typed              = typed;
    r.want.best_start    = OUT_W'(start);
    r.want.best_length   = OUT_W'(span);
    r.want.few_distinct  = few;
    r.want.too_long      = 1'b0;
    directed_rows.push_back(r);
  endfunction

  // Receiver side: m_axis_tready drops in random bursts.
  always @(posedge clk) begin
    if (rst || !rx_stall_on) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every result request taken by the receiver is matched against the
  // oldest owed result, field by field.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed, tdata=%h tuser=%b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_axis_tdata[10:0] !== want.best_start)
          report_mismatch($sformatf("best_start got %0d want %0d",
                                    m_axis_tdata[10:0], want.best_start));
        if (m_axis_tdata[21:11] !== want.best_length)
          report_mismatch($sformatf("best_length got %0d want %0d",
                                    m_axis_tdata[21:11], want.best_length));
        if (m_axis_tuser[0] !== want.few_distinct)
          report_mismatch($sformatf("few_distinct got %b want %b",
                                    m_axis_tuser[0], want.few_distinct));
        if (m_axis_tuser[1] !== want.too_long)
          report_mismatch($sformatf("too_long got %b want %b",
                                    m_axis_tuser[1], want.too_long));
      end
    end
  end

  initial begin
    logic [LIM_W-1:0] limit_plan [10];
    int unsigned      phase_items;
    int unsigned      len;

    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    tx_gaps_on      = 1'b1;
    rx_stall_on     = 1'b1;
    mismatch_count  = 0;
    results_checked = 0;
    symbols_sent    = 0;
    strings_sent    = 0;
    limit_reg       = LIMIT_RESET;
    clear_window();

    // Directed strings, run under the reset limit of two.
    // Single symbols: the lowest, the highest code beyond the alphabet, and the highest in it.
    add_row(5'd0,  1'b1, 1'b1, 1, 1, 1'b1);
    add_row(5'd31, 1'b1, 1'b1, 1, 1, 1'b1);
    add_row(5'd25, 1'b1, 1'b1, 1, 1, 1'b1);
    // One symbol repeated stays below the limit over the whole string.
    add_row(5'd3,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd3,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd3,  1'b1, 1'b1, 1, 3, 1'b1);
    // A third symbol pushes out the first; the first window of two is kept.
    add_row(5'd0,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd1,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd2,  1'b1, 1'b1, 1, 2, 1'b0);
    // A later window that outgrows the first one.
    add_row(5'd1,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd2,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd1,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd2,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd3,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd3,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd3,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd3,  1'b1, 1'b0, 0, 0, 1'b0);
    // Walking one across the symbol bits.
    add_row(5'd16, 1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd8,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd4,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd2,  1'b0, 1'b0, 0, 0, 1'b0);
    add_row(5'd1,  1'b1, 1'b0, 0, 0, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_symbol(directed_rows[i].sym, directed_rows[i].last,
                  directed_rows[i].typed, directed_rows[i].want);

    // Random phases, each under its own limit: the smallest, a limit equal to
    // the alphabet, zero, values beyond the alphabet, and other fixed and random ones.
    limit_plan = '{5'd1, 5'd3, 5'd26, 5'd0, 5'd31, 5'd27,
                   LIM_W'($urandom_range(4, 25)), LIM_W'($urandom_range(1, 25)),
                   5'd2, LIM_W'($urandom_range(0, 31))};
    for (int ph = 0; ph < 10; ph++) begin
      wait_until_drained();
      write_limit(limit_plan[ph]);
      // One quiet phase in the middle; the final phase runs with no idling.
      tx_gaps_on  = (ph != 4 && ph != 9);
      rx_stall_on = (ph != 4 && ph != 9);
      phase_items = 0;
      // A string that overruns the history store by a single symbol.
      if (ph == 1) send_random_string(MAX_LEN + 1, 1'b0);
      while (phase_items < 75) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
        send_random_string(len, 1'b0);
        phase_items += len;
      end
    end

    wait_until_drained();
    $display("Sent %0d symbols in %0d strings over ten limit settings.",
             symbols_sent, strings_sent);
    $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
